[rtl/core/pta_pkg.sv]
// ----------------------------------------------------------------------------
// Page table aging tracker package
// Shared types and constants for the page table with aging counters.
// ----------------------------------------------------------------------------
package pta_pkg;

  localparam int unsigned KIND_W  = 3;
  localparam int unsigned PAGE_W  = 8;
  localparam int unsigned FRAME_W = 6;
  localparam int unsigned AGE_W   = 8;

  // Number of physical frames; a map to a frame at or above this is ignored.
  localparam int unsigned FRAMES = 64;

  typedef enum logic [KIND_W-1:0] {
    KIND_LOOKUP = 3'd0,
    KIND_MAP    = 3'd1,
    KIND_INVAL  = 3'd2,
    KIND_REF    = 3'd3,
    KIND_TICK   = 3'd4
  } kind_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_OP,
    ST_TICK_RD,
    ST_TICK_WR
  } state_t;

  typedef struct packed {
    logic               valid;
    logic               ref_bit;
    logic [AGE_W-1:0]   age;
    logic [FRAME_W-1:0] frame;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic   wr;
    entry_t entry;
  } upd_t;

  typedef struct packed {
    logic               hit;
    logic [FRAME_W-1:0] frame_out;
    logic [AGE_W-1:0]   age;
    logic               referenced;
  } result_t;

endpackage

[rtl/core/pta_ram.sv]
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module pta_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/core/pta_entry_unit.sv]
// ----------------------------------------------------------------------------
// Page table entry update unit
// Computes the new state of one entry for a page operation or an aging tick.
// ----------------------------------------------------------------------------
module pta_entry_unit
  import pta_pkg::*;
(
  input  logic [KIND_W-1:0]  kind,
  input  logic [FRAME_W-1:0] frame,
  input  entry_t             old_entry,
  output upd_t               upd
);

  always_comb begin
    upd.wr    = 1'b0;
    upd.entry = old_entry;
    unique case (kind)
      KIND_MAP: begin
        if (32'(frame) < FRAMES) begin
          upd.wr          = 1'b1;
          upd.entry.frame = frame;
          upd.entry.valid = 1'b1;
        end
      end
      KIND_INVAL: begin
        upd.wr          = 1'b1;
        upd.entry.valid = 1'b0;
      end
      KIND_REF: begin
        upd.wr            = 1'b1;
        upd.entry.ref_bit = 1'b1;
      end
      KIND_TICK: begin
        if (old_entry.valid) begin
          upd.wr            = 1'b1;
          upd.entry.age     = {old_entry.ref_bit, old_entry.age[AGE_W-1:1]};
          upd.entry.ref_bit = 1'b0;
        end
      end
      default: begin
        upd.wr = 1'b0;
      end
    endcase
  end

endmodule

[rtl/core/page_table_aging_tracker_core.sv]
// ----------------------------------------------------------------------------
// Page table aging tracker
// A page table with per-entry frame, valid bit, reference bit and aging
// counter, held in one RAM and updated by a shared entry unit.
// ----------------------------------------------------------------------------
// A transaction is taken when start is high and busy is low. Lookup, map,
// invalidate and reference each pass through a read step, which fetches the
// entry from the RAM, and an update step, which writes it back, before the
// next acceptance; the result shows on done for one cycle right after. An
// aging tick walks every entry through the same read and write path, one
// entry at a time. After reset the block clears the RAM one entry per cycle
// and stays busy until every entry is cleared. The receiver cannot stall
// results, so done must be sampled in the cycle it is high.
module page_table_aging_tracker_core
  import pta_pkg::*;
#(
  parameter int unsigned PAGES = 256
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [KIND_W-1:0]  kind,
  input  logic [PAGE_W-1:0]  page,
  input  logic [FRAME_W-1:0] frame,
  output logic               done,
  output logic               hit,
  output logic [FRAME_W-1:0] frame_out,
  output logic [AGE_W-1:0]   age,
  output logic               referenced
);

  localparam int unsigned AW = $clog2(PAGES);
  localparam logic [AW-1:0] LAST = AW'(PAGES - 1);

  state_t             state, state_next;
  logic [AW-1:0]      cnt, cnt_next;
  logic [KIND_W-1:0]  kind_q;
  logic [AW-1:0]      page_q;
  logic [FRAME_W-1:0] frame_q;
  logic               page_ok_q;
  logic               done_next;
  result_t            res, res_next;

  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [AW-1:0]      ram_raddr;
  entry_t             ram_wdata;
  logic [ENTRY_W-1:0] ram_rdata;
  logic [KIND_W-1:0]  unit_kind;
  upd_t               upd;
  logic               res_ok;

  pta_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(PAGES)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  pta_entry_unit u_unit (
    .kind     (unit_kind),
    .frame    (frame_q),
    .old_entry(entry_t'(ram_rdata)),
    .upd      (upd)
  );

  assign busy = (state != ST_IDLE);

  assign res_ok = page_ok_q && (kind_q == KIND_LOOKUP || kind_q == KIND_MAP ||
                                kind_q == KIND_INVAL || kind_q == KIND_REF);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      cnt   <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      done  <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      kind_q    <= kind;
      page_q    <= AW'(page);
      frame_q   <= frame;
      page_ok_q <= (32'(page) < PAGES);
    end
    if (done_next) begin
      res <= res_next;
    end
  end

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    done_next  = 1'b0;
    res_next   = '0;
    ram_we     = 1'b0;
    ram_waddr  = page_q;
    ram_raddr  = page_q;
    ram_wdata  = upd.entry;
    unit_kind  = kind_q;
    unique case (state)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = cnt;
        ram_wdata = '0;
        if (cnt == LAST) begin
          cnt_next   = '0;
          state_next = ST_IDLE;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      ST_IDLE: begin
        if (start) begin
          if (kind == KIND_TICK) begin
            cnt_next   = '0;
            state_next = ST_TICK_RD;
          end else begin
            state_next = ST_READ;
          end
        end
      end
      ST_READ: begin
        state_next = ST_OP;
      end
      ST_OP: begin
        ram_we    = upd.wr && page_ok_q;
        done_next = 1'b1;
        if (res_ok) begin
          res_next.hit        = upd.entry.valid;
          res_next.frame_out  = upd.entry.valid ? upd.entry.frame : '0;
          res_next.age        = upd.entry.age;
          res_next.referenced = upd.entry.ref_bit;
        end
        state_next = ST_IDLE;
      end
      ST_TICK_RD: begin
        ram_raddr  = cnt;
        state_next = ST_TICK_WR;
      end
      ST_TICK_WR: begin
        unit_kind = KIND_TICK;
        ram_we    = upd.wr;
        ram_waddr = cnt;
        if (cnt == LAST) begin
          cnt_next   = '0;
          done_next  = 1'b1;
          state_next = ST_IDLE;
        end else begin
          cnt_next   = cnt + 1'b1;
          state_next = ST_TICK_RD;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign hit        = res.hit;
  assign frame_out  = res.frame_out;
  assign age        = res.age;
  assign referenced = res.referenced;

`ifndef ASSERT_OFF
  a_done_source: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == ST_OP || state == ST_TICK_WR))
    else $error("done raised without a finished transaction");

  a_idle_no_write: assert property (@(posedge clk) disable iff (rst)
    state == ST_IDLE |-> !ram_we)
    else $error("table written while idle");

  a_miss_no_frame: assert property (@(posedge clk) disable iff (rst)
    done && !hit |-> frame_out == '0)
    else $error("frame reported on a miss");
`endif

endmodule

[tb/sv/page_table_aging_tracker_checker.sv]
// ----------------------------------------------------------------------------
// Page table aging tracker checker
// Watches the request and result channels of the page table core. It keeps
// its own copy of the table, works out the entry state each accepted
// transaction should report, and compares every result strobe against the
// oldest outstanding prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module page_table_aging_tracker_checker
  import pta_pkg::*;
#(
  parameter int unsigned PAGES = 256
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               busy,
  input  logic [KIND_W-1:0]  kind,
  input  logic [PAGE_W-1:0]  page,
  input  logic [FRAME_W-1:0] frame,
  input  logic               done,
  input  logic               hit,
  input  logic [FRAME_W-1:0] frame_out,
  input  logic [AGE_W-1:0]   age,
  input  logic               referenced,
  output int                 errors,
  output int                 pending
);

  logic               valid_m [PAGES];
  logic               ref_m   [PAGES];
  logic [AGE_W-1:0]   age_m   [PAGES];
  logic [FRAME_W-1:0] frame_m [PAGES];

  result_t expected_entries[$];
  int      mismatches;

  function automatic result_t apply_request(input logic [KIND_W-1:0]  k,
                                            input logic [PAGE_W-1:0]  p,
                                            input logic [FRAME_W-1:0] f);
    result_t r;
    r = '0;
    if (k == KIND_TICK) begin
      for (int i = 0; i < PAGES; i++) begin
        if (valid_m[i]) begin
          age_m[i] = {ref_m[i], age_m[i][AGE_W-1:1]};
          ref_m[i] = 1'b0;
        end
      end
      return r;
    end
    if (k > KIND_TICK || p >= PAGES) begin
      return r;
    end
    case (k)
      KIND_MAP: begin
        if (f < FRAMES) begin
          frame_m[p] = f;
          valid_m[p] = 1'b1;
        end
      end
      KIND_INVAL: begin
        valid_m[p] = 1'b0;
      end
      KIND_REF: begin
        ref_m[p] = 1'b1;
      end
      default: begin
      end
    endcase
    r.hit        = valid_m[p];
    r.frame_out  = valid_m[p] ? frame_m[p] : '0;
    r.age        = age_m[p];
    r.referenced = ref_m[p];
    return r;
  endfunction

  task automatic flag(input string what, input result_t want, input result_t got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%0t: %s: expected hit=%0d frame=%0d age=0x%02h ref=%0d, got hit=%0d frame=%0d age=0x%02h ref=%0d",
               $realtime, what, want.hit, want.frame_out, want.age, want.referenced,
               got.hit, got.frame_out, got.age, got.referenced);
    end
  endtask

  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (rst) begin
      for (int i = 0; i < PAGES; i++) begin
        valid_m[i] = 1'b0;
        ref_m[i]   = 1'b0;
        age_m[i]   = '0;
        frame_m[i] = '0;
      end
      expected_entries.delete();
      mismatches = 0;
      errors  <= 0;
      pending <= 0;
    end else begin
      if (done) begin
        got.hit        = hit;
        got.frame_out  = frame_out;
        got.age        = age;
        got.referenced = referenced;
        if (expected_entries.size() == 0) begin
          flag("result with no transaction outstanding", '0, got);
        end else begin
          want = expected_entries.pop_front();
          if (got.hit !== want.hit || got.frame_out !== want.frame_out ||
              got.age !== want.age || got.referenced !== want.referenced) begin
            flag("result mismatch", want, got);
          end
        end
      end
      if (start && !busy) begin
        expected_entries.push_back(apply_request(kind, page, frame));
      end
      errors  <= mismatches;
      pending <= expected_entries.size();
    end
  end

endmodule

[tb/sv/page_table_aging_tracker_core_tb.sv]
// ----------------------------------------------------------------------------
// Page table aging tracker testbench
// Drives lookup, map, invalidate, reference, aging tick and unused-kind
// transactions into the core: a directed sequence through the aging and
// validity corner cases, then random traffic focused on a small set of pages
// so that entries age and get remapped. A separate checker predicts and
// compares every result.
`timescale 1ns / 1ps
module page_table_aging_tracker_core_tb;
  import pta_pkg::*;

  localparam int unsigned PAGES        = 256;
  localparam int unsigned KIND_LAST    = (1 << KIND_W) - 1;
  localparam int unsigned RANDOM_ITEMS = 1100;
  localparam int unsigned CYCLE_LIMIT  = 3_000_000;

  logic               clk   = 1'b0;
  logic               rst   = 1'b1;
  logic               start = 1'b0;
  logic [KIND_W-1:0]  kind  = KIND_LOOKUP;
  logic [PAGE_W-1:0]  page  = '0;
  logic [FRAME_W-1:0] frame = '0;
  logic               busy;
  logic               done;
  logic               hit;
  logic [FRAME_W-1:0] frame_out;
  logic [AGE_W-1:0]   age;
  logic               referenced;

  int          errors;
  int          pending;
  int unsigned cycles = 0;
  bit          no_gap = 1'b0;

  logic [PAGE_W-1:0] hot_pages [8] = '{8'd0, 8'd1, 8'd85, 8'd128,
                                       8'd170, 8'd200, 8'd254, 8'd255};

  page_table_aging_tracker_core #(
    .PAGES(PAGES)
  ) uut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .kind       (kind),
    .page       (page),
    .frame      (frame),
    .done       (done),
    .hit        (hit),
    .frame_out  (frame_out),
    .age        (age),
    .referenced (referenced)
  );

  page_table_aging_tracker_checker #(
    .PAGES(PAGES)
  ) checker_i (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .kind       (kind),
    .page       (page),
    .frame      (frame),
    .done       (done),
    .hit        (hit),
    .frame_out  (frame_out),
    .age        (age),
    .referenced (referenced),
    .errors     (errors),
    .pending    (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("page_table_aging_tracker_core_tb NOT OK");
      $finish;
    end
  end

  task automatic issue(input logic [KIND_W-1:0]  k,
                       input logic [PAGE_W-1:0]  p,
                       input logic [FRAME_W-1:0] f);
    int gap;
    gap = no_gap ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    kind  <= k;
    page  <= p;
    frame <= f;
    do @(posedge clk); while (busy);
  endtask

  initial begin
    int                sel;
    logic [KIND_W-1:0] k;
    logic [PAGE_W-1:0] p;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    issue(KIND_LOOKUP, 8'd0,   6'd0);
    issue(KIND_MAP,    8'd0,   6'd0);
    issue(KIND_MAP,    8'd255, 6'd63);
    issue(KIND_LOOKUP, 8'd255, 6'd0);
    issue(KIND_REF,    8'd255, 6'd0);
    issue(KIND_REF,    8'd10,  6'd0);
    issue(KIND_TICK,   8'd0,   6'd63);
    issue(KIND_LOOKUP, 8'd255, 6'd0);
    issue(KIND_LOOKUP, 8'd10,  6'd0);
    issue(KIND_MAP,    8'd10,  6'd21);
    issue(KIND_TICK,   8'd255, 6'd0);
    issue(KIND_LOOKUP, 8'd10,  6'd0);
    issue(KIND_LOOKUP, 8'd255, 6'd0);
    issue(KIND_INVAL,  8'd255, 6'd0);
    issue(KIND_LOOKUP, 8'd255, 6'd0);
    issue(KIND_TICK,   8'd0,   6'd0);
    issue(KIND_LOOKUP, 8'd255, 6'd0);
    issue(KIND_MAP,    8'd255, 6'd42);
    issue(KIND_REF,    8'd0,   6'd0);
    issue(KIND_MAP,    8'd0,   6'd63);
    issue(3'(KIND_TICK + 1), 8'd255, 6'd63);
    issue(3'(KIND_LAST),     8'd0,   6'd0);
    issue(KIND_INVAL,  8'd128, 6'd0);
    issue(KIND_LOOKUP, 8'd170, 6'd42);

    start <= 1'b0;
    do @(posedge clk); while (pending != 0);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 64 == 0) begin
        no_gap = ($urandom_range(0, 3) == 0);
      end
      sel = $urandom_range(0, 99);
      if (sel < 30) begin
        k = KIND_LOOKUP;
      end else if (sel < 52) begin
        k = KIND_MAP;
      end else if (sel < 62) begin
        k = KIND_INVAL;
      end else if (sel < 88) begin
        k = KIND_REF;
      end else if (sel < 95) begin
        k = KIND_TICK;
      end else begin
        k = KIND_W'($urandom_range(KIND_TICK + 1, KIND_LAST));
      end
      if ($urandom_range(0, 9) < 7) begin
        p = hot_pages[3'($urandom_range(0, 7))];
      end else begin
        p = PAGE_W'($urandom_range(0, 255));
      end
      issue(k, p, FRAME_W'($urandom_range(0, 63)));
    end

    start <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (10) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("page_table_aging_tracker_core_tb OK");
    end else begin
      $display("page_table_aging_tracker_core_tb NOT OK");
    end
    $finish;
  end

endmodule
